[design/pnia_pkg.sv]
// Types, codes and reset values shared by the pack node id assignment sequencer.
`timescale 1ns / 1ps
package pnia_pkg;

   typedef enum logic [3:0] {
      ST_IDLE           = 4'd0,
      ST_WAIT_REQUEST   = 4'd1,
      ST_START          = 4'd2,
      ST_SLAVE_SELECT   = 4'd3,
      ST_SELECT_CONFIRM = 4'd4,
      ST_WAIT_CONFIRM   = 4'd5,
      ST_AUTH_START     = 4'd6,
      ST_AUTHORIZING    = 4'd7,
      ST_VERIFY         = 4'd8,
      ST_ASSIGNED       = 4'd9,
      ST_FAILURE        = 4'd10,
      ST_WAIT_DESELECT  = 4'd11
   } st_type;

   typedef enum logic [3:0] {
      ACT_NONE         = 4'd0,
      ACT_SELECT       = 4'd1,
      ACT_DESELECT     = 4'd2,
      ACT_SEND_EMPTY   = 4'd3,
      ACT_SEND_ID      = 4'd4,
      ACT_READ_SERIAL  = 4'd5,
      ACT_RESTART_LINK = 4'd6,
      ACT_SUCCESS      = 4'd7,
      ACT_FAILURE      = 4'd8
   } act_type;

   localparam logic [2:0] FUNC_START = 3'd0;
   localparam logic [2:0] FUNC_TICK  = 3'd1;
   localparam logic [2:0] FUNC_POLL  = 3'd2;
   localparam logic [2:0] FUNC_FRAME = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   localparam logic [2:0] CSR_WAIT_TMO   = 3'd0;
   localparam logic [2:0] CSR_AUTH_TMO   = 3'd1;
   localparam logic [2:0] CSR_DESEL_WAIT = 3'd2;
   localparam logic [2:0] CSR_NODE_OFS   = 3'd3;
   localparam logic [2:0] CSR_FRAME_ID   = 3'd4;

   localparam logic [15:0] WAIT_TMO_RST   = 16'd500;
   localparam logic [15:0] AUTH_TMO_RST   = 16'd6000;
   localparam logic [15:0] DESEL_WAIT_RST = 16'd4000;
   localparam logic [7:0]  NODE_OFS_RST   = 8'd5;
   localparam logic [10:0] FRAME_ID_RST   = 11'h070;

   typedef struct packed {
      logic [15:0] wait_tmo;
      logic [15:0] auth_tmo;
      logic [15:0] desel_wait;
      logic [7:0]  node_ofs;
      logic [10:0] frame_id;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  pack_id;
      logic        select_ok;
      logic [10:0] frame_id;
      logic [7:0]  frame_byte;
      logic        is_read_serial;
      logic        cmd_success;
      logic        charge_known;
   } req_type;

   typedef struct packed {
      act_type    action;
      logic [7:0] pack;
      logic [7:0] payload;
   } res_type;

   typedef struct packed {
      res_type [2:0] res;
      logic [1:0]    cnt;
      logic          status;
      logic          busy;
   } bun_type;

   function automatic res_type mk_res(input act_type act, input logic [7:0] pk,
                                      input logic [7:0] pl);
      res_type r;
      r.action  = act;
      r.pack    = pk;
      r.payload = pl;
      return r;
   endfunction

endpackage

[design/pack_node_id_assign_fsm.sv]
// Top level of the pack node id assignment and authorisation sequencer.
//
//   channel  ports                       handshake       direction
//   req      req_func .. req_charge_known req_valid/stall in
//   rsp      rsp_action .. rsp_last       rsp_valid/stall out
//   csr      csr_index, csr_data          csr_valid/ready in
//
// An item is registered and processed, and its one to three results are held in
// a bundle register and handed out one per cycle while rsp_stall is low.
// Reset is synchronous and returns the sequencer to idle with reset values.
// rsp_stall holds the current result; req_stall rises while a registered item waits for the bundle.
`timescale 1ns / 1ps
module pack_node_id_assign_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_pack_id,
   input  logic        req_select_ok,
   input  logic [10:0] req_frame_id,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_is_read_serial,
   input  logic        req_cmd_success,
   input  logic        req_charge_known,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_action,
   output logic [7:0]  rsp_action_pack,
   output logic [7:0]  rsp_payload,
   output logic        rsp_status,
   output logic        rsp_busy_pack_valid,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pnia_pkg::*;

   req_type req_ff;
   logic    in_vld_ff, in_vld_in;
   logic    free;
   logic    fire;
   logic    accept;
   cfg_type cfg;
   bun_type bun;

   assign fire      = in_vld_ff && free;
   assign req_stall = in_vld_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept)    in_vld_in = 1'b1;
      else if (fire) in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func           <= req_func;
         req_ff.pack_id        <= req_pack_id;
         req_ff.select_ok      <= req_select_ok;
         req_ff.frame_id       <= req_frame_id;
         req_ff.frame_byte     <= req_frame_byte;
         req_ff.is_read_serial <= req_is_read_serial;
         req_ff.cmd_success    <= req_cmd_success;
         req_ff.charge_known   <= req_charge_known;
      end
   end

   pnia_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pnia_step u_step (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg),
      .bun   (bun)
   );

   pnia_out u_out (
      .clock               (clock),
      .reset               (reset),
      .load                (fire),
      .bun_in              (bun),
      .free                (free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_action_pack     (rsp_action_pack),
      .rsp_payload         (rsp_payload),
      .rsp_status          (rsp_status),
      .rsp_busy_pack_valid (rsp_busy_pack_valid),
      .rsp_last            (rsp_last)
   );

endmodule

[design/pnia_csr.sv]
// Configuration register file of the node id assignment sequencer.
`timescale 1ns / 1ps
module pnia_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output pnia_pkg::cfg_type cfg
);
   import pnia_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WAIT_TMO:   cfg_in.wait_tmo   = csr_data;
            CSR_AUTH_TMO:   cfg_in.auth_tmo   = csr_data;
            CSR_DESEL_WAIT: cfg_in.desel_wait = csr_data;
            CSR_NODE_OFS:   cfg_in.node_ofs   = csr_data[7:0];
            CSR_FRAME_ID:   cfg_in.frame_id   = csr_data[10:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_tmo   <= WAIT_TMO_RST;
         cfg_ff.auth_tmo   <= AUTH_TMO_RST;
         cfg_ff.desel_wait <= DESEL_WAIT_RST;
         cfg_ff.node_ofs   <= NODE_OFS_RST;
         cfg_ff.frame_id   <= FRAME_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/pnia_step.sv]
// Protocol state, timeout and action selection for one item.
`timescale 1ns / 1ps
module pnia_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pnia_pkg::req_type req,
   input  pnia_pkg::cfg_type cfg,
   output pnia_pkg::bun_type bun
);
   import pnia_pkg::*;

   st_type      st_ff, st_in;
   logic [7:0]  pack_ff, pack_in;
   logic        pv_ff, pv_in;
   logic [15:0] tl_ff, tl_in;
   logic [15:0] tr_ff, tr_in;
   logic [8:0]  node_sum;
   logic        frame_hit;
   logic        tl_zero;

   assign node_sum  = {1'b0, pack_ff} + {1'b0, cfg.node_ofs};
   assign frame_hit = (req.frame_id == cfg.frame_id) && pv_ff;
   assign tl_zero   = (tl_ff == 16'd0);

   always_comb begin
      st_in   = st_ff;
      pack_in = pack_ff;
      pv_in   = pv_ff;
      tl_in   = tl_ff;
      tr_in   = tr_ff;
      case (req.func)
         FUNC_START: begin
            pv_in = req.select_ok;
            tl_in = cfg.wait_tmo;
            tr_in = cfg.wait_tmo;
            if (req.select_ok) begin
               st_in   = ST_WAIT_REQUEST;
               pack_in = req.pack_id;
            end else begin
               st_in   = ST_IDLE;
               pack_in = 8'd0;
            end
         end
         FUNC_TICK: begin
            if (!tl_zero) tl_in = tl_ff - 16'd1;
         end
         FUNC_POLL: begin
            if (pv_ff) begin
               case (st_ff)
                  ST_WAIT_REQUEST, ST_SLAVE_SELECT, ST_WAIT_CONFIRM,
                  ST_AUTHORIZING: begin
                     if (tl_zero) st_in = ST_FAILURE;
                  end
                  ST_START: begin
                     if (!req.select_ok) begin
                        st_in = ST_FAILURE;
                     end else begin
                        st_in = ST_SLAVE_SELECT;
                        tl_in = tr_ff;
                     end
                  end
                  ST_SELECT_CONFIRM: begin
                     st_in = ST_WAIT_CONFIRM;
                     tl_in = tr_ff;
                  end
                  ST_AUTH_START: begin
                     if (!req.select_ok) begin
                        st_in = ST_FAILURE;
                     end else begin
                        st_in = ST_AUTHORIZING;
                        tl_in = cfg.auth_tmo;
                        tr_in = cfg.auth_tmo;
                     end
                  end
                  ST_VERIFY: begin
                     if (tl_zero) st_in = ST_FAILURE;
                     else if (req.charge_known) st_in = ST_ASSIGNED;
                  end
                  ST_ASSIGNED: begin
                     st_in   = ST_IDLE;
                     pack_in = 8'd0;
                     pv_in   = 1'b0;
                     tl_in   = cfg.wait_tmo;
                     tr_in   = cfg.wait_tmo;
                  end
                  ST_FAILURE: begin
                     st_in = ST_WAIT_DESELECT;
                     tl_in = cfg.desel_wait;
                     tr_in = cfg.desel_wait;
                  end
                  ST_WAIT_DESELECT: begin
                     if (tl_zero) begin
                        st_in   = ST_IDLE;
                        pack_in = 8'd0;
                        pv_in   = 1'b0;
                        tl_in   = cfg.wait_tmo;
                        tr_in   = cfg.wait_tmo;
                     end
                  end
                  default: st_in = st_ff;
               endcase
            end
         end
         FUNC_FRAME: begin
            if (frame_hit) begin
               case (st_ff)
                  ST_WAIT_REQUEST: st_in = ST_START;
                  ST_SLAVE_SELECT: st_in = ST_SELECT_CONFIRM;
                  ST_WAIT_CONFIRM: begin
                     if ({1'b0, req.frame_byte} == node_sum) begin
                        st_in = ST_AUTH_START;
                        tl_in = cfg.auth_tmo;
                        tr_in = cfg.auth_tmo;
                     end
                  end
                  default: st_in = st_ff;
               endcase
            end
         end
         FUNC_READ: begin
            if (pv_ff && req.pack_id == pack_ff && req.is_read_serial)
               st_in = req.cmd_success ? ST_VERIFY : ST_FAILURE;
         end
         default: st_in = st_ff;
      endcase
   end

   always_comb begin
      bun      = '0;
      bun.busy = pv_in;
      case (req.func)
         FUNC_START: begin
            bun.status = !req.select_ok;
            if (pv_ff) begin
               bun.res[0] = mk_res(ACT_DESELECT, pack_ff, 8'd0);
               bun.res[1] = mk_res(ACT_SELECT, req.pack_id, 8'd0);
               bun.res[2] = mk_res(ACT_FAILURE, req.pack_id, 8'd0);
               bun.cnt    = req.select_ok ? 2'd2 : 2'd3;
            end else begin
               bun.res[0] = mk_res(ACT_SELECT, req.pack_id, 8'd0);
               bun.res[1] = mk_res(ACT_FAILURE, req.pack_id, 8'd0);
               bun.cnt    = req.select_ok ? 2'd1 : 2'd2;
            end
         end
         FUNC_POLL: begin
            if (!pv_ff) begin
               bun.status = 1'b1;
            end else begin
               case (st_ff)
                  ST_START: begin
                     bun.res[0] = mk_res(ACT_DESELECT, pack_ff, 8'd0);
                     bun.res[1] = mk_res(ACT_SEND_EMPTY, pack_ff, 8'd0);
                     bun.cnt    = req.select_ok ? 2'd2 : 2'd1;
                  end
                  ST_SELECT_CONFIRM: begin
                     bun.res[0] = mk_res(ACT_SEND_ID, pack_ff, node_sum[7:0]);
                     bun.cnt    = 2'd1;
                  end
                  ST_AUTH_START: begin
                     bun.res[0] = mk_res(ACT_SELECT, pack_ff, 8'd0);
                     bun.res[1] = mk_res(ACT_READ_SERIAL, pack_ff, 8'd0);
                     bun.cnt    = req.select_ok ? 2'd2 : 2'd1;
                  end
                  ST_AUTHORIZING: bun.status = tl_zero;
                  ST_VERIFY: begin
                     bun.status = tl_zero;
                     if (!tl_zero && req.charge_known) begin
                        bun.res[0] = mk_res(ACT_RESTART_LINK, pack_ff, 8'd0);
                        bun.cnt    = 2'd1;
                     end
                  end
                  ST_ASSIGNED: begin
                     bun.res[0] = mk_res(ACT_SUCCESS, pack_ff, 8'd0);
                     bun.cnt    = 2'd1;
                  end
                  ST_FAILURE: begin
                     bun.res[0] = mk_res(ACT_DESELECT, pack_ff, 8'd0);
                     bun.cnt    = 2'd1;
                  end
                  ST_WAIT_DESELECT: begin
                     if (tl_zero) begin
                        bun.res[0] = mk_res(ACT_FAILURE, pack_ff, 8'd0);
                        bun.cnt    = 2'd1;
                     end
                  end
                  default: bun.cnt = 2'd0;
               endcase
            end
         end
         default: bun.cnt = 2'd0;
      endcase
      // quiet item: one empty result
      if (bun.cnt == 2'd0) begin
         bun.res[0] = mk_res(ACT_NONE, 8'd0, 8'd0);
         bun.cnt    = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         pack_ff <= 8'd0;
         pv_ff   <= 1'b0;
         tl_ff   <= WAIT_TMO_RST;
         tr_ff   <= WAIT_TMO_RST;
      end else if (fire) begin
         st_ff   <= st_in;
         pack_ff <= pack_in;
         pv_ff   <= pv_in;
         tl_ff   <= tl_in;
         tr_ff   <= tr_in;
      end
   end

   a_idle_no_pack: assert property (@(posedge clock) disable iff (reset)
      !pv_ff |-> (st_ff == ST_IDLE && pack_ff == 8'd0))
      else $error("no pack held outside idle");
   a_idle_has_no_pack: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> !pv_ff)
      else $error("pack held in idle");
   a_timer_bound: assert property (@(posedge clock) disable iff (reset)
      tl_ff <= tr_ff)
      else $error("countdown above its reload");

endmodule

[design/pnia_out.sv]
// Result bundle register that hands out the results of one item in order.
`timescale 1ns / 1ps
module pnia_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pnia_pkg::bun_type bun_in,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_action,
   output logic [7:0]        rsp_action_pack,
   output logic [7:0]        rsp_payload,
   output logic              rsp_status,
   output logic              rsp_busy_pack_valid,
   output logic              rsp_last
);
   import pnia_pkg::*;

   bun_type    bun_ff;
   logic       vld_ff, vld_in;
   logic [1:0] idx_ff, idx_in;
   res_type    cur;

   assign cur                 = bun_ff.res[idx_ff];
   assign rsp_valid           = vld_ff;
   assign rsp_action          = cur.action;
   assign rsp_action_pack     = cur.pack;
   assign rsp_payload         = cur.payload;
   assign rsp_status          = bun_ff.status;
   assign rsp_busy_pack_valid = bun_ff.busy;
   assign rsp_last            = (idx_ff == bun_ff.cnt - 2'd1);
   assign free                = !vld_ff || (!rsp_stall && rsp_last);

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = 2'd0;
      end else if (vld_ff && !rsp_stall) begin
         if (rsp_last) vld_in = 1'b0;
         else          idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) bun_ff <= bun_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (bun_ff.cnt != 2'd0 && idx_ff < bun_ff.cnt))
      else $error("result index beyond bundle");
   a_none_alone: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && cur.action == ACT_NONE) |-> (bun_ff.cnt == 2'd1))
      else $error("empty result mixed with actions");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("bundle overwritten before drained");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the pack node id assignment sequencer, with its own predictor.
`timescale 1ns / 1ps
module testbench;
   import pnia_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   typedef struct {
      act_type    action;
      logic [7:0] pack;
      logic [7:0] payload;
      logic       status;
      logic       busy;
      logic       last;
   } action_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_pack_id = '0;
   logic        req_select_ok = 1'b0;
   logic [10:0] req_frame_id = '0;
   logic [7:0]  req_frame_byte = '0;
   logic        req_is_read_serial = 1'b0;
   logic        req_cmd_success = 1'b0;
   logic        req_charge_known = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_action;
   logic [7:0]  rsp_action_pack;
   logic [7:0]  rsp_payload;
   logic        rsp_status;
   logic        rsp_busy_pack_valid;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   st_type      seq_state;
   logic [7:0]  seq_pack;
   logic        seq_busy;
   logic [15:0] seq_time_left;
   logic [15:0] seq_time_reload;
   cfg_type     seq_cfg;

   action_rec_type expected_actions[$];
   action_rec_type item_actions[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   pack_node_id_assign_fsm dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   // predictor
   function automatic void add_action(input act_type act, input logic [7:0] pk,
                                      input logic [7:0] pl);
      action_rec_type r;
      r.action  = act;
      r.pack    = pk;
      r.payload = pl;
      r.status  = 1'b0;
      r.busy    = 1'b0;
      r.last    = 1'b0;
      if (item_actions.size() < 3) item_actions.push_back(r);
   endfunction

   function automatic void load_timer(input logic [15:0] dur);
      seq_time_reload = dur;
      seq_time_left   = dur;
   endfunction

   function automatic void go_idle();
      seq_state = ST_IDLE;
      seq_pack  = '0;
      seq_busy  = 1'b0;
      load_timer(seq_cfg.wait_tmo);
   endfunction

   function automatic logic poll_step(input logic sel_ok, input logic charge);
      logic [7:0] pk;
      logic [7:0] node;
      pk   = seq_pack;
      node = seq_pack + seq_cfg.node_ofs;
      if (!seq_busy) return 1'b1;
      case (seq_state)
         ST_WAIT_REQUEST, ST_SLAVE_SELECT, ST_WAIT_CONFIRM:
            if (seq_time_left == 0) seq_state = ST_FAILURE;
         ST_START: begin
            add_action(ACT_DESELECT, pk, 8'd0);
            if (!sel_ok) seq_state = ST_FAILURE;
            else begin
               add_action(ACT_SEND_EMPTY, pk, 8'd0);
               seq_state     = ST_SLAVE_SELECT;
               seq_time_left = seq_time_reload;
            end
         end
         ST_SELECT_CONFIRM: begin
            add_action(ACT_SEND_ID, pk, node);
            seq_time_left = seq_time_reload;
            seq_state     = ST_WAIT_CONFIRM;
         end
         ST_AUTH_START: begin
            add_action(ACT_SELECT, pk, 8'd0);
            if (!sel_ok) seq_state = ST_FAILURE;
            else begin
               add_action(ACT_READ_SERIAL, pk, 8'd0);
               seq_state = ST_AUTHORIZING;
               load_timer(seq_cfg.auth_tmo);
            end
         end
         ST_AUTHORIZING:
            if (seq_time_left == 0) begin
               seq_state = ST_FAILURE;
               return 1'b1;
            end
         ST_VERIFY: begin
            if (seq_time_left == 0) begin
               seq_state = ST_FAILURE;
               return 1'b1;
            end
            if (charge) begin
               seq_state = ST_ASSIGNED;
               add_action(ACT_RESTART_LINK, pk, 8'd0);
            end
         end
         ST_ASSIGNED: begin
            add_action(ACT_SUCCESS, pk, 8'd0);
            go_idle();
         end
         ST_FAILURE: begin
            add_action(ACT_DESELECT, pk, 8'd0);
            load_timer(seq_cfg.desel_wait);
            seq_state = ST_WAIT_DESELECT;
         end
         ST_WAIT_DESELECT:
            if (seq_time_left == 0) begin
               add_action(ACT_FAILURE, pk, 8'd0);
               go_idle();
            end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic predict_item(input req_type it);
      logic        status;
      action_rec_type r;
      item_actions.delete();
      status = 1'b0;
      case (it.func)
         FUNC_START: begin
            if (seq_busy) add_action(ACT_DESELECT, seq_pack, 8'd0);
            go_idle();
            seq_pack  = it.pack_id;
            seq_busy  = 1'b1;
            seq_state = ST_WAIT_REQUEST;
            add_action(ACT_SELECT, it.pack_id, 8'd0);
            if (!it.select_ok) begin
               add_action(ACT_FAILURE, it.pack_id, 8'd0);
               go_idle();
               status = 1'b1;
            end
         end
         FUNC_TICK:
            if (seq_time_left != 0) seq_time_left = seq_time_left - 16'd1;
         FUNC_POLL:
            status = poll_step(it.select_ok, it.charge_known);
         FUNC_FRAME:
            if (it.frame_id == seq_cfg.frame_id && seq_busy) begin
               if (seq_state == ST_WAIT_REQUEST) seq_state = ST_START;
               else if (seq_state == ST_SLAVE_SELECT) seq_state = ST_SELECT_CONFIRM;
               else if (seq_state == ST_WAIT_CONFIRM &&
                        {1'b0, it.frame_byte} == {1'b0, seq_pack} + {1'b0, seq_cfg.node_ofs})
               begin
                  seq_state = ST_AUTH_START;
                  load_timer(seq_cfg.auth_tmo);
               end
            end
         FUNC_READ:
            if (seq_busy && it.pack_id == seq_pack && it.is_read_serial)
               seq_state = it.cmd_success ? ST_VERIFY : ST_FAILURE;
         default: ;
      endcase
      if (item_actions.size() == 0) add_action(ACT_NONE, 8'd0, 8'd0);
      foreach (item_actions[k]) begin
         r        = item_actions[k];
         r.status = status;
         r.busy   = seq_busy;
         r.last   = (k == item_actions.size() - 1);
         expected_actions.push_back(r);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      action_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            $error("unexpected item: action %0d pack %0d", rsp_action, rsp_action_pack);
            mismatch_count++;
         end else begin
            want = expected_actions.pop_front();
            if (rsp_action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_action);
               mismatch_count++;
            end
            if (rsp_action_pack !== want.pack) begin
               $error("action_pack: expected %0d, got %0d", want.pack, rsp_action_pack);
               mismatch_count++;
            end
            if (rsp_payload !== want.payload) begin
               $error("payload: expected %0d, got %0d", want.payload, rsp_payload);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_busy_pack_valid !== want.busy) begin
               $error("busy_pack_valid: expected %0d, got %0d", want.busy,
                      rsp_busy_pack_valid);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   function automatic req_type make_req(input logic [2:0] func, input logic [7:0] pk,
                                        input logic sel, input logic [10:0] fid,
                                        input logic [7:0] fbyte, input logic sn,
                                        input logic ok, input logic charge);
      req_type it;
      it.func           = func;
      it.pack_id        = pk;
      it.select_ok      = sel;
      it.frame_id       = fid;
      it.frame_byte     = fbyte;
      it.is_read_serial = sn;
      it.cmd_success    = ok;
      it.charge_known   = charge;
      return it;
   endfunction

   function automatic req_type noise_item();
      req_type it;
      it.func           = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
      it.pack_id        = 8'($urandom_range(0, 250));
      it.select_ok      = 1'($urandom_range(1));
      it.frame_id       = $urandom_range(1) ? seq_cfg.frame_id : 11'($urandom_range(0, 2047));
      it.frame_byte     = 8'($urandom_range(0, 255));
      it.is_read_serial = 1'($urandom_range(1));
      it.cmd_success    = 1'($urandom_range(1));
      it.charge_known   = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_type guided_item();
      req_type it;
      int      r;
      it = noise_item();
      r  = $urandom_range(5);
      it.select_ok = ($urandom_range(9) != 0);
      it.frame_id  = ($urandom_range(7) != 0) ? seq_cfg.frame_id : it.frame_id;
      case (seq_state)
         ST_IDLE:
            it.func = FUNC_START;
         ST_WAIT_REQUEST, ST_SLAVE_SELECT, ST_WAIT_CONFIRM: begin
            it.func = (r < 2) ? FUNC_TICK : (r == 2) ? FUNC_POLL : FUNC_FRAME;
            if ($urandom_range(4) != 0) it.frame_byte = seq_pack + seq_cfg.node_ofs;
         end
         ST_AUTHORIZING: begin
            it.func = (r < 2) ? FUNC_TICK : (r == 2) ? FUNC_POLL : FUNC_READ;
            if ($urandom_range(5) != 0) it.pack_id = seq_pack;
            it.is_read_serial = ($urandom_range(9) != 0);
            it.cmd_success    = ($urandom_range(5) != 0);
         end
         ST_VERIFY, ST_WAIT_DESELECT:
            it.func = (r < 2) ? FUNC_TICK : FUNC_POLL;
         default:
            it.func = FUNC_POLL;
      endcase
      return it;
   endfunction

   task automatic send_item(input req_type it);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_func           <= it.func;
      req_pack_id        <= it.pack_id;
      req_select_ok      <= it.select_ok;
      req_frame_id       <= it.frame_id;
      req_frame_byte     <= it.frame_byte;
      req_is_read_serial <= it.is_read_serial;
      req_cmd_success    <= it.cmd_success;
      req_charge_known   <= it.charge_known;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_item(it);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WAIT_TMO:   seq_cfg.wait_tmo   = val;
         CSR_AUTH_TMO:   seq_cfg.auth_tmo   = val;
         CSR_DESEL_WAIT: seq_cfg.desel_wait = val;
         CSR_NODE_OFS:   seq_cfg.node_ofs   = val[7:0];
         CSR_FRAME_ID:   seq_cfg.frame_id   = val[10:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] wait_tmo, input logic [15:0] auth_tmo,
                             input logic [15:0] desel_wait, input logic [7:0] node_ofs,
                             input logic [10:0] frame_id);
      hold_until_drained();
      write_reg(CSR_WAIT_TMO, wait_tmo);
      write_reg(CSR_AUTH_TMO, auth_tmo);
      write_reg(CSR_DESEL_WAIT, desel_wait);
      write_reg(CSR_NODE_OFS, {8'd0, node_ofs});
      write_reg(CSR_FRAME_ID, {5'd0, frame_id});
   endtask

   task automatic drive_random_items(input int count);
      req_type it;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) hold_until_drained();
         it = ($urandom_range(3) == 0) ? noise_item() : guided_item();
         send_item(it);
      end
   endtask

   task automatic test_quiet_items();
      send_item(make_req(FUNC_TICK, 8'd0, 1'b0, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd250, 1'b1, 11'h7FF, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_item(make_req(FUNC_FRAME, 8'd5, 1'b0, seq_cfg.frame_id, 8'd5, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_UNUSED, 8'd170, 1'b1, 11'h555, 8'hAA, 1'b1, 1'b1, 1'b1));
   endtask

   task automatic test_restart_and_assign();
      logic [10:0] fid;
      logic [7:0]  node;
      fid  = seq_cfg.frame_id;
      node = 8'd250 + seq_cfg.node_ofs;
      send_item(make_req(FUNC_START, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_START, 8'd1, 1'b0, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_START, 8'd250, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, fid, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, fid, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, fid, node, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_READ, 8'd250, 1'b0, 11'd0, 8'd0, 1'b1, 1'b1, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b1));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
   endtask

   task automatic test_node_wrap_timeouts();
      set_config(16'd0, AUTH_TMO_RST, 16'd1, 8'd255, 11'h7FF);
      send_item(make_req(FUNC_START, 8'd250, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, 11'h7FF, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, 11'h7FF, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_FRAME, 8'd0, 1'b0, 11'h7FF, 8'd249, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_TICK, 8'd0, 1'b0, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      send_item(make_req(FUNC_POLL, 8'd0, 1'b1, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0));
   endtask

   task automatic test_random_flat();
      set_config(16'd3, 16'd4, 16'd2, 8'd0, 11'd0);
      send_idle_pct = 0;
      stall_pct     = 0;
      drive_random_items(22);
   endtask

   task automatic test_sender_gaps();
      set_config(16'hFFFF, 16'd1, 16'hFFFF, 8'd255, 11'($urandom_range(0, 2047)));
      send_idle_pct = 54;
      stall_pct     = 0;
      drive_random_items(22);
   endtask

   task automatic test_receiver_stalls();
      set_config(16'd1, 16'hFFFF, 16'd1, 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)));
      send_idle_pct = 0;
      stall_pct     = 54;
      drive_random_items(22);
   endtask

   task automatic test_mixed_idling();
      set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 4)), 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)));
      send_idle_pct = 14;
      stall_pct     = 14;
      drive_random_items(22);
   endtask

   initial begin
      seq_cfg.wait_tmo   = WAIT_TMO_RST;
      seq_cfg.auth_tmo   = AUTH_TMO_RST;
      seq_cfg.desel_wait = DESEL_WAIT_RST;
      seq_cfg.node_ofs   = NODE_OFS_RST;
      seq_cfg.frame_id   = FRAME_ID_RST;
      go_idle();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_quiet_items();
      test_restart_and_assign();
      test_node_wrap_timeouts();
      test_random_flat();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();

      hold_until_drained();
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
